@@ rtl/murmur3_x86_32_hash_assert.svh @@
// Assertion macros shared by the MurmurHash3 block.
`ifndef MURMUR3_X86_32_HASH_ASSERT_SVH
`define MURMUR3_X86_32_HASH_ASSERT_SVH

`ifndef SYNTH
// Concurrent property checked on every rising edge outside reset.
`define MM3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define MM3_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MM3_ASSERT(label, clk, rst_n, prop, msg)
`define MM3_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/mm3_pkg.sv @@
// Package with the constants and control types of the MurmurHash3 block.
`timescale 1ns / 1ps

package mm3_pkg;

    // Mixing and finalization constants of MurmurHash3 x86_32.
    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

    // Number of bytes in a full body block.
    localparam logic [2:0] BLOCK_BYTES = 3'd4;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;      // capture an input transfer and do the first multiply
        logic mul2;      // rotate and second multiply of the block
        logic mix;       // fold the block into the running hash
        logic fin1;      // length fold and first finalization multiply
        logic fin2;      // second finalization multiply
        logic out_load;  // last xor-shift into the output register
    } mm3_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // the item being worked on ends the message
        logic out_busy;  // the output register holds a result that stays this cycle
    } mm3_stat_t;

endpackage

@@ rtl/murmur3_x86_32_hash.sv @@
// Top level of the streaming MurmurHash3 x86_32 hasher.
//
//   Channel  Ports                                                  Moves
//   cfg      cfg_we, cfg_wdata                                      seed write, no wait
//   input    s_valid/s_ready, s_data_word, s_byte_count, s_last     one word per transfer
//   output   m_valid/m_ready, m_hash_value                          one hash per message
//
// A body word goes through the input multiply, the second block multiply and
// the mix into the running hash, all in one shared datapath stepped by the controller.
// The last word is then finalized: length fold and multiply, second multiply, xor-shift.
// A finished hash waits in the output register while the next message is taken in;
// the last finalization step stalls only when that register still holds a result.
// Reset is synchronous and active low; the seed resets to zero.
`timescale 1ns / 1ps

`include "murmur3_x86_32_hash_assert.svh"

module murmur3_x86_32_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    mm3_pkg::mm3_cmd_t  cmd;
    mm3_pkg::mm3_stat_t stat;

    // Sequencer.
    mm3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and state.
    mm3_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_hash_value (m_hash_value),
        .cmd          (cmd),
        .stat         (stat)
    );

    // The controller issues one command at a time.
    `MM3_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0(cmd), "more than one datapath command")
    // An accepted word goes through the second multiply and then the mix.
    `MM3_ASSERT(a_block_seq, aclk, aresetn, cmd.load |=> cmd.mul2 ##1 cmd.mix, "block sequence broken")
    // The input is closed while a word is in the datapath.
    `MM3_ASSERT(a_ready_drop, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "input open while busy")
    // A waiting result is never overwritten.
    `MM3_ASSERT_NEVER(a_no_overwrite, aclk, aresetn, cmd.out_load && m_valid && !m_ready, "result overwritten")

endmodule

@@ rtl/mm3_dp.sv @@
// Datapath of the MurmurHash3 block: block scrambling, hash mixing and finalization.
`timescale 1ns / 1ps

module mm3_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [31:0]       s_data_word,
    input  logic [2:0]        s_byte_count,
    input  logic              s_last,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [31:0]       m_hash_value,
    input  mm3_pkg::mm3_cmd_t cmd,
    output mm3_pkg::mm3_stat_t stat
);

    logic [31:0] seed_reg;
    logic        active_reg, active_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] fin_reg, fin_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [31:0] out_reg, out_next;
    logic        valid_reg, valid_next;

    logic [2:0]  eff_count;
    logic [31:0] byte_mask;
    logic [31:0] mix_x;
    logic [31:0] mix_rot;
    logic [31:0] fin_t;
    logic [31:0] k_rot;

    // Bytes that count: a body item is always four, a count above four is four.
    always_comb begin
        if (!s_last || (s_byte_count > mm3_pkg::BLOCK_BYTES)) begin
            eff_count = mm3_pkg::BLOCK_BYTES;
        end else begin
            eff_count = s_byte_count;
        end
    end

    // Keep only the valid low bytes of the word.
    always_comb begin
        unique case (eff_count)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'h0000_00ff;
            3'd2:    byte_mask = 32'h0000_ffff;
            3'd3:    byte_mask = 32'h00ff_ffff;
            default: byte_mask = 32'hffff_ffff;
        endcase
    end

    assign k_rot   = {k_reg[16:0], k_reg[31:17]};
    assign mix_x   = hash_reg ^ k_reg;
    assign mix_rot = {mix_x[18:0], mix_x[31:19]};
    assign fin_t   = hash_reg ^ len_reg;

    // Next-state logic of the datapath registers, steered by the controller.
    always_comb begin
        active_next = active_reg;
        hash_next   = hash_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        fin_next    = fin_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        out_next    = out_reg;
        valid_next  = valid_reg && !m_ready;

        if (cmd.load) begin
            // A new message starts from the seed with a zero length.
            if (!active_reg) begin
                hash_next = seed_reg;
                len_next  = 32'd0;
            end
            active_next = 1'b1;
            k_next      = (s_data_word & byte_mask) * mm3_pkg::MIX_C1;
            cnt_next    = eff_count;
            last_next   = s_last;
        end

        if (cmd.mul2) begin
            k_next = k_rot * mm3_pkg::MIX_C2;
        end

        if (cmd.mix) begin
            // A full block is mixed, a tail is only xored in, an empty tail does nothing.
            if (cnt_reg == mm3_pkg::BLOCK_BYTES) begin
                hash_next = {mix_rot[29:0], 2'b00} + mix_rot + mm3_pkg::MIX_ADD;
            end else if (cnt_reg != 3'd0) begin
                hash_next = mix_x;
            end
            len_next = len_reg + {29'd0, cnt_reg};
            if (last_reg) begin
                active_next = 1'b0;
            end
        end

        if (cmd.fin1) begin
            fin_next = (fin_t ^ {16'd0, fin_t[31:16]}) * mm3_pkg::FIN_C1;
        end

        if (cmd.fin2) begin
            fin_next = (fin_reg ^ {13'd0, fin_reg[31:13]}) * mm3_pkg::FIN_C2;
        end

        if (cmd.out_load) begin
            out_next   = fin_reg ^ {16'd0, fin_reg[31:16]};
            valid_next = 1'b1;
        end
    end

    // Control registers take reset; the payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= 32'd0;
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
        len_reg  <= len_next;
        k_reg    <= k_next;
        fin_reg  <= fin_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign m_valid       = valid_reg;
    assign m_hash_value  = out_reg;
    assign stat.last     = last_reg;
    assign stat.out_busy = valid_reg && !m_ready;

endmodule

@@ rtl/mm3_ctrl.sv @@
// Controller state machine that sequences the MurmurHash3 datapath.
`timescale 1ns / 1ps

module mm3_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mm3_pkg::mm3_stat_t stat,
    output mm3_pkg::mm3_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL2 = 6'b000010,
        ST_MIX  = 6'b000100,
        ST_FIN1 = 6'b001000,
        ST_FIN2 = 6'b010000,
        ST_FIN3 = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Transitions and the command issued in each state.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = stat.last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                cmd.fin1   = 1'b1;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                cmd.fin2   = 1'b1;
                state_next = ST_FIN3;
            end
            ST_FIN3: begin
                // Wait until the previous result has left the output register.
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
